// ===== design/bcev_pkg.sv =====
package bcev_pkg;

  // Combined word: raw buttons below, ten virtual bits above
  localparam int WORD_BITS        = 22;
  localparam int VIRT_BITS        = 10;
  localparam int RAW_WIDTH        = 12;
  localparam int AXIS_WIDTH       = 16;
  localparam int HAT_WIDTH        = 10;
  localparam int THR_WIDTH        = 15;
  localparam int NUM_WIDTH        = 5;
  localparam int IN_TDATA_WIDTH   = 88;
  localparam int OUT_TDATA_WIDTH  = 8;
  localparam int CFG_DATA_WIDTH   = 15;

  localparam int RAW_BUTTONS_DFLT = 12;
  localparam int QUEUE_DEPTH_DFLT = 2;

  // Configuration register indexes
  localparam logic REG_AXIS_THRESHOLD = 1'b0;
  localparam logic REG_EVENTS_ENABLE  = 1'b1;

  localparam logic [THR_WIDTH-1:0] THR_RESET = 15'd16384;

  // Hat angles in degrees
  localparam logic signed [HAT_WIDTH-1:0] HAT_N  = 10'sd0;
  localparam logic signed [HAT_WIDTH-1:0] HAT_NE = 10'sd45;
  localparam logic signed [HAT_WIDTH-1:0] HAT_E  = 10'sd90;
  localparam logic signed [HAT_WIDTH-1:0] HAT_SE = 10'sd135;
  localparam logic signed [HAT_WIDTH-1:0] HAT_S  = 10'sd180;
  localparam logic signed [HAT_WIDTH-1:0] HAT_SW = 10'sd225;
  localparam logic signed [HAT_WIDTH-1:0] HAT_W  = 10'sd270;
  localparam logic signed [HAT_WIDTH-1:0] HAT_NW = 10'sd315;

  // One queued sample: bits that changed and the new word
  typedef struct packed {
    logic [WORD_BITS-1:0] changed;
    logic [WORD_BITS-1:0] cur;
  } bcev_entry_t;

endpackage

// ===== design/button_change_event_generator_unit.sv =====
// Gamepad change-event generator. Each input word is one gamepad sample; the
// front end updates the axis and hat latches, builds the 22-bit combined word
// and compares it with the previous one in the cycle the word is accepted. A
// sample with changed bits (and events enabled) enters a queue of
// QUEUE_DEPTH entries; the input is ready whenever the queue has room. The
// back end emits one event per changed bit, lowest bit first, one per clock
// while out_tready allows, so a sample with N changed bits gives N events (up
// to 22); this event walk sets the sustained rate. Results go out through a
// registered output stage. Writes to the configuration port take effect on
// the next word.
module button_change_event_generator_unit import bcev_pkg::*; #(
  parameter int RAW_BUTTONS = RAW_BUTTONS_DFLT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DFLT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // raw_buttons[11:0], left_x[27:12], left_y[43:28], right_x[59:44],
  // right_y[75:60], hat_angle[85:76], zero pad
  input  logic [IN_TDATA_WIDTH-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // button_number[4:0], pressed[5], zero pad
  output logic [OUT_TDATA_WIDTH-1:0]  out_tdata,
  output logic                        out_tlast,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]   cfg_wdata
);

  bcev_entry_t push_entry, head;
  logic        push, pop, empty, full;

  bcev_front #(
    .RAW_BUTTONS(RAW_BUTTONS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (full),
    .q_push    (push),
    .q_entry   (push_entry)
  );

  bcev_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  bcev_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (head),
    .q_empty    (empty),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== design/bcev_front.sv =====
module bcev_front import bcev_pkg::*; #(
  parameter int RAW_BUTTONS = RAW_BUTTONS_DFLT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [IN_TDATA_WIDTH-1:0]  in_tdata,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
  input  logic                       q_full,
  output logic                       q_push,
  output bcev_entry_t                q_entry
);

  localparam logic [31:0] RAW_MASK = (32'd1 << RAW_BUTTONS) - 32'd1;

  logic [THR_WIDTH-1:0] thr_r;
  logic                 ena_r;
  logic [WORD_BITS-1:0] prev_r, prev_nxt;
  logic [3:0]           axis_r, axis_nxt;
  logic [1:0]           hat_r, hat_nxt;

  logic [RAW_WIDTH-1:0]          raw;
  logic signed [AXIS_WIDTH-1:0]  lx_in, ly_in, rx_in, ry_in;
  logic signed [HAT_WIDTH-1:0]   hat;
  logic signed [AXIS_WIDTH:0]    lx, ly, rx, ry, thr_p, thr_m;
  logic                          up, down, left, right;
  logic [VIRT_BITS-1:0]          virt;
  logic [31:0]                   wide;
  logic [WORD_BITS-1:0]          cur, changed;
  logic                          accept;

  function automatic logic latch_next(input logic cur_bit,
                                      input logic signed [AXIS_WIDTH:0] pos,
                                      input logic signed [AXIS_WIDTH:0] hi,
                                      input logic signed [AXIS_WIDTH:0] lo);
    logic r;
    r = cur_bit;
    if (pos > hi) begin
      r = 1'b1;
    end else if (pos < lo) begin
      r = 1'b0;
    end
    return r;
  endfunction

  // Unpack the word, Y axes negated one bit wider
  always_comb begin
    raw   = in_tdata[11:0];
    lx_in = in_tdata[27:12];
    ly_in = in_tdata[43:28];
    rx_in = in_tdata[59:44];
    ry_in = in_tdata[75:60];
    hat   = in_tdata[85:76];
    lx    = (AXIS_WIDTH+1)'(lx_in);
    ly    = -((AXIS_WIDTH+1)'(ly_in));
    rx    = (AXIS_WIDTH+1)'(rx_in);
    ry    = -((AXIS_WIDTH+1)'(ry_in));
    thr_p = signed'({2'b00, thr_r});
    thr_m = -thr_p;
  end

  // Decode hat directions and update latches
  always_comb begin
    up    = (hat == HAT_N)  || (hat == HAT_NW) || (hat == HAT_NE);
    down  = (hat == HAT_S)  || (hat == HAT_SW) || (hat == HAT_SE);
    left  = (hat == HAT_W)  || (hat == HAT_NW) || (hat == HAT_SW);
    right = (hat == HAT_E)  || (hat == HAT_SE) || (hat == HAT_NE);

    axis_nxt[0] = latch_next(axis_r[0], lx, thr_p, thr_m);
    axis_nxt[1] = latch_next(axis_r[1], ly, thr_p, thr_m);
    axis_nxt[2] = latch_next(axis_r[2], rx, thr_p, thr_m);
    axis_nxt[3] = latch_next(axis_r[3], ry, thr_p, thr_m);

    hat_nxt = hat_r;
    if (right) begin
      hat_nxt[0] = 1'b1;
    end else if (left) begin
      hat_nxt[0] = 1'b0;
    end
    if (up) begin
      hat_nxt[1] = 1'b1;
    end else if (down) begin
      hat_nxt[1] = 1'b0;
    end

    virt    = {right, left, down, up, hat_nxt, axis_nxt};
    wide    = (32'(raw) & RAW_MASK) | (32'(virt) << RAW_BUTTONS);
    cur     = wide[WORD_BITS-1:0];
    changed = prev_r ^ cur;
    prev_nxt = cur;
  end

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Queue only samples that produce events
  assign q_push          = accept && ena_r && (changed != '0);
  assign q_entry.changed = changed;
  assign q_entry.cur     = cur;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      ena_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AXIS_THRESHOLD: thr_r <= cfg_wdata[THR_WIDTH-1:0];
        REG_EVENTS_ENABLE:  ena_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Advance tracked state on every accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      axis_r <= '0;
      hat_r  <= '0;
    end else if (accept) begin
      prev_r <= prev_nxt;
      axis_r <= axis_nxt;
      hat_r  <= hat_nxt;
    end
  end

endmodule

// ===== design/bcev_queue.sv =====
module bcev_queue import bcev_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DFLT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  bcev_entry_t push_entry,
  input  logic        pop,
  output bcev_entry_t head,
  output logic        empty,
  output logic        full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bcev_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/bcev_back.sv =====
module bcev_back import bcev_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bcev_entry_t                 q_head,
  input  logic                        q_empty,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [OUT_TDATA_WIDTH-1:0]  out_tdata,
  output logic                        out_tlast
);

  logic                 busy_r;
  logic [WORD_BITS-1:0] mask_r, cur_r;
  logic                 vld_r;
  logic [NUM_WIDTH-1:0] num_r;
  logic                 prs_r, lst_r;

  logic [NUM_WIDTH-1:0] lo_idx;
  logic [WORD_BITS-1:0] rem;
  logic                 emit, last;

  // Find the lowest pending bit
  always_comb begin
    lo_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        lo_idx = NUM_WIDTH'(i);
      end
    end
    rem  = mask_r & ~(WORD_BITS'(1) << lo_idx);
    last = (rem == '0);
    emit = busy_r && (!vld_r || out_tready);
    q_pop = !q_empty && (!busy_r || (emit && last));
  end

  // Walk the changed bits of one word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
    end else if (emit && last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mask_r <= q_head.changed;
      cur_r  <= q_head.cur;
    end else if (emit) begin
      mask_r <= rem;
    end
  end

  // Hold the event until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (emit) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      num_r <= lo_idx + 1'b1;
      prs_r <= cur_r[lo_idx];
      lst_r <= last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {2'b00, prs_r, num_r};
  assign out_tlast  = lst_r;

endmodule

// ===== tb/sv/tb_button_change_event_generator_unit.sv =====
`timescale 1ns / 1ps

module tb_button_change_event_generator_unit;
  import bcev_pkg::*;

  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 30;
  localparam int QUIET_LIMIT  = 3000;

  localparam logic signed [HAT_WIDTH-1:0]  HAT_IDLE = -10'sd1;
  localparam logic signed [AXIS_WIDTH-1:0] AXIS_MAX = 16'sh7FFF;
  localparam logic signed [AXIS_WIDTH-1:0] AXIS_MIN = 16'sh8000;

  // One gamepad sample, packed so that raw_buttons lands in the lowest bits
  typedef struct packed {
    logic [HAT_WIDTH-1:0]  hat;
    logic [AXIS_WIDTH-1:0] ry;
    logic [AXIS_WIDTH-1:0] rx;
    logic [AXIS_WIDTH-1:0] ly;
    logic [AXIS_WIDTH-1:0] lx;
    logic [RAW_WIDTH-1:0]  raw;
  } sample_t;

  typedef struct packed {
    logic [NUM_WIDTH-1:0] number;
    logic                 pressed;
    logic                 last;
  } change_t;

  // Tracks latches and the previous combined word, and holds the change
  // events still owed by the block
  class button_events;
    logic [THR_WIDTH-1:0] threshold;
    bit                   events_on;
    logic [WORD_BITS-1:0] prev_word;
    logic [3:0]           axis_bits;
    logic [1:0]           hat_bits;
    change_t              due[$];
    int                   errors;

    function new();
      threshold = THR_RESET;
      events_on = 1'b1;
      prev_word = '0;
      axis_bits = '0;
      hat_bits  = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic index, logic [CFG_DATA_WIDTH-1:0] value);
      if (index == REG_AXIS_THRESHOLD)
        threshold = value[THR_WIDTH-1:0];
      else
        events_on = value[0];
    endfunction

    function logic hysteresis(logic held, int pos, int lim);
      if (pos > lim)
        return 1'b1;
      if (pos < -lim)
        return 1'b0;
      return held;
    endfunction

    // Update latches, build the combined word and queue one event per changed bit
    function void take_sample(sample_t s);
      int                         lim;
      logic signed [HAT_WIDTH-1:0] hat;
      logic                        up, down, left, right;
      logic [VIRT_BITS-1:0]        virt;
      logic [WORD_BITS-1:0]        word, diff;
      change_t                     ev;
      lim = int'(threshold);
      hat = s.hat;
      axis_bits[0] = hysteresis(axis_bits[0], int'($signed(s.lx)), lim);
      axis_bits[1] = hysteresis(axis_bits[1], -int'($signed(s.ly)), lim);
      axis_bits[2] = hysteresis(axis_bits[2], int'($signed(s.rx)), lim);
      axis_bits[3] = hysteresis(axis_bits[3], -int'($signed(s.ry)), lim);
      up    = (hat == HAT_NW) || (hat == HAT_N) || (hat == HAT_NE);
      down  = (hat == HAT_SE) || (hat == HAT_S) || (hat == HAT_SW);
      left  = (hat == HAT_SW) || (hat == HAT_W) || (hat == HAT_NW);
      right = (hat == HAT_NE) || (hat == HAT_E) || (hat == HAT_SE);
      if (right)
        hat_bits[0] = 1'b1;
      else if (left)
        hat_bits[0] = 1'b0;
      if (up)
        hat_bits[1] = 1'b1;
      else if (down)
        hat_bits[1] = 1'b0;
      virt = {right, left, down, up, hat_bits, axis_bits};
      word = {virt, s.raw};
      diff = word ^ prev_word;
      prev_word = word;
      if (!events_on)
        return;
      for (int i = 0; i < WORD_BITS; i++) begin
        if (diff[i]) begin
          diff[i]    = 1'b0;
          ev.number  = NUM_WIDTH'(i + 1);
          ev.pressed = word[i];
          ev.last    = (diff == '0);
          due.push_back(ev);
        end
      end
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void check_event(logic [NUM_WIDTH-1:0] number, logic pressed, logic last);
      change_t want;
      if (due.size() == 0) begin
        $error("unexpected event: button_number %0d pressed %0b", number, pressed);
        errors++;
        return;
      end
      want = due.pop_front();
      if (number !== want.number) begin
        $error("button_number: expected %0d, actual %0d", want.number, number);
        errors++;
      end
      if (pressed !== want.pressed) begin
        $error("pressed: expected %0b, actual %0b", want.pressed, pressed);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_event: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [IN_TDATA_WIDTH-1:0]  in_tdata;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0] out_tdata;
  logic                       out_tlast;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata;

  button_events          book;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    hold_asks = 0;
  int                    hold_done = 0;
  int                    hold_left = 0;
  int                    quiet_cycles = 0;
  logic [RAW_WIDTH-1:0]  last_raw = '0;
  logic [HAT_WIDTH-1:0]  hat_points [9] = '{HAT_IDLE, HAT_N, HAT_NE, HAT_E, HAT_SE,
                                            HAT_S, HAT_SW, HAT_W, HAT_NW};

  button_change_event_generator_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_asks != hold_done) begin
      hold_done = hold_asks;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every event word the block hands over
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      book.check_event(out_tdata[NUM_WIDTH-1:0], out_tdata[NUM_WIDTH], out_tlast);
  end

  // Stop a hung run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic set_idling(int sender_pct, int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  // Offer one sample, idling first at random, and hold it until taken
  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = IN_TDATA_WIDTH'(s);
    do @(posedge clk); while (!in_tready);
    book.take_sample(s);
    last_raw = s.raw;
    @(negedge clk);
  endtask

  task automatic send_fields(logic [RAW_WIDTH-1:0] raw, logic [AXIS_WIDTH-1:0] lx,
                             logic [AXIS_WIDTH-1:0] ly, logic [AXIS_WIDTH-1:0] rx,
                             logic [AXIS_WIDTH-1:0] ry, logic [HAT_WIDTH-1:0] hat);
    sample_t s;
    s = '{hat: hat, ry: ry, rx: rx, ly: ly, lx: lx, raw: raw};
    send_sample(s);
  endtask

  // Drop valid and wait until every owed event has come out
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (book.pending() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic index, logic [CFG_DATA_WIDTH-1:0] value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    book.set_reg(index, value);
  endtask

  // Axis values cluster around the hysteresis edges, the extremes and zero, with some fully random
  function automatic logic [AXIS_WIDTH-1:0] rand_axis();
    int lim;
    int v;
    lim = int'(book.threshold);
    case ($urandom_range(0, 6))
      0: v = $urandom_range(0, 65535);
      1: v = lim + int'($urandom_range(0, 2)) - 1;
      2: v = -lim + int'($urandom_range(0, 2)) - 1;
      3: v = 32767;
      4: v = -32768;
      5: v = int'($urandom_range(0, 2000)) - 1000;
      default: v = 0;
    endcase
    return v[AXIS_WIDTH-1:0];
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int      h;
    case ($urandom_range(0, 9))
      0, 1: s.raw = last_raw;
      2, 3: s.raw = RAW_WIDTH'($urandom_range(0, 4095));
      default: begin
        s.raw = last_raw ^ (12'd1 << $urandom_range(0, RAW_WIDTH - 1));
        if ($urandom_range(0, 1))
          s.raw ^= 12'd1 << $urandom_range(0, RAW_WIDTH - 1);
      end
    endcase
    s.lx = rand_axis();
    s.ly = rand_axis();
    s.rx = rand_axis();
    s.ry = rand_axis();
    if ($urandom_range(0, 9) < 7) begin
      s.hat = hat_points[$urandom_range(0, 8)];
    end else begin
      h = int'($urandom_range(0, 360)) - 1;
      s.hat = h[HAT_WIDTH-1:0];
    end
    return s;
  endfunction

  // Random samples; optionally ask for a long receiver hold-off or pause to drain
  task automatic send_random(int count, int hold_at, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at)
        hold_asks++;
      if (i == pause_at)
        wait_drained();
      send_sample(rand_sample());
    end
  endtask

  initial begin
    logic [CFG_DATA_WIDTH-1:0] thr_pick;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_AXIS_THRESHOLD;
    cfg_wdata = '0;
    book = new();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    set_idling(29, 74);
    write_reg(REG_AXIS_THRESHOLD, THR_RESET);
    write_reg(REG_EVENTS_ENABLE, 1);

    // Directed: no change, full raw toggles, axis extremes, every hat angle
    send_fields(12'h000, 0, 0, 0, 0, HAT_IDLE);
    send_fields(12'hFFF, 0, 0, 0, 0, HAT_IDLE);
    send_fields(12'h000, 0, 0, 0, 0, HAT_IDLE);
    send_fields(12'hA5A, AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN, HAT_N);
    send_fields(12'hA5A, AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN, HAT_N);
    send_fields(12'h5A5, AXIS_MIN, AXIS_MAX, AXIS_MIN, AXIS_MAX, HAT_S);
    // axis exactly at the threshold holds its latch
    send_fields(12'h5A5, 16384, -16384, 16384, -16384, HAT_NE);
    send_fields(12'h5A5, 16385, -16385, 16385, -16385, HAT_E);
    send_fields(12'h5A5, -16385, 16385, -16385, 16385, HAT_SE);
    send_fields(12'h5A5, 0, 0, 0, 0, HAT_SW);
    send_fields(12'h5A5, 0, 0, 0, 0, HAT_W);
    send_fields(12'h5A5, 0, 0, 0, 0, HAT_NW);
    // angles off the eight points decode to no direction
    send_fields(12'h5A5, 0, 0, 0, 0, 10'sd359);
    send_fields(12'h5A5, 0, 0, 0, 0, 10'sd44);
    send_fields(12'h5A5, 0, 0, 0, 0, 10'sd1);
    send_fields(12'h800, 0, 0, 0, 0, HAT_IDLE);
    send_fields(12'h001, 0, 0, 0, 0, HAT_IDLE);
    send_fields(12'hFFF, AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN, HAT_NE);
    send_fields(12'h000, AXIS_MIN, AXIS_MAX, AXIS_MIN, AXIS_MAX, HAT_SW);
    send_fields(12'hFFF, AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN, HAT_SE);
    send_fields(12'h000, 0, 0, 0, 0, HAT_IDLE);

    send_random(130, 40, 90);

    set_idling(74, 29);
    write_reg(REG_AXIS_THRESHOLD, 0);
    send_random(80, -1, -1);

    // Events off: state still tracks, nothing comes out
    write_reg(REG_EVENTS_ENABLE, 0);
    send_random(30, -1, -1);
    write_reg(REG_EVENTS_ENABLE, 1);

    set_idling(0, 0);
    write_reg(REG_AXIS_THRESHOLD, 15'h7FFF);
    send_random(80, -1, -1);

    thr_pick = CFG_DATA_WIDTH'($urandom_range(1, 32766));
    write_reg(REG_AXIS_THRESHOLD, thr_pick);
    send_random(70, -1, -1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (book.errors == 0 && book.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
